@@ hw/rtl/nstw_pkg.sv @@
package nstw_pkg;

    localparam int NODES       = 256;
    localparam int SWITCHES    = 256;
    localparam int LENGTH_BITS = 16;

    localparam int NODE_AW  = $clog2(NODES);
    localparam int SW_AW    = $clog2(SWITCHES);
    localparam int STEP_W   = $clog2(NODES + 2);
    localparam int TOTAL_W  = 24;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_SWITCH = 2'd1;
    localparam logic [1:0] OP_WALK   = 2'd2;
    localparam logic [1:0] OP_FIND   = 2'd3;

    localparam logic [1:0] KIND_SENSOR = 2'd1;
    localparam logic [1:0] KIND_BRANCH = 2'd2;
    localparam logic [1:0] KIND_EXIT   = 2'd3;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_LOOP = 2'd2;

    typedef logic [2:0] t_res_kind;
    localparam t_res_kind RES_ZERO  = 3'd0;
    localparam t_res_kind RES_WALK  = 3'd1;
    localparam t_res_kind RES_LOOP  = 3'd2;
    localparam t_res_kind RES_FOUND = 3'd3;
    localparam t_res_kind RES_MISS  = 3'd4;

    typedef struct packed {
        logic [1:0]             kind;
        logic [7:0]             number;
        logic [7:0]             s_dest;
        logic [LENGTH_BITS-1:0] s_len;
        logic [7:0]             c_dest;
        logic [LENGTH_BITS-1:0] c_len;
    } t_node;

    localparam int NODE_W = $bits(t_node);

    typedef struct packed {
        logic [7:0]  node_index;
        logic [1:0]  node_kind;
        logic [7:0]  node_number;
        logic [7:0]  straight_dest;
        logic [15:0] straight_length;
        logic [7:0]  curved_dest;
        logic [15:0] curved_length;
        logic [7:0]  switch_number;
        logic        switch_curved;
    } t_req;

    typedef struct packed {
        logic      wr_node;
        logic      wr_switch;
        logic      walk_start;
        logic      sw_issue;
        logic      walk_step;
        logic      find_start;
        logic      find_next;
        logic      res_set;
        t_res_kind res_kind;
        logic      out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic walk_stop;
        logic step_limit;
        logic find_match;
        logic find_last;
        logic out_free;
    } t_dp_stat;

endpackage

@@ hw/rtl/nstw_req_if.sv @@
interface nstw_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  node_index;
    logic [1:0]  node_kind;
    logic [7:0]  node_number;
    logic [7:0]  straight_dest;
    logic [15:0] straight_length;
    logic [7:0]  curved_dest;
    logic [15:0] curved_length;
    logic [7:0]  switch_number;
    logic        switch_curved;

    modport source (
        output valid, opcode, node_index, node_kind, node_number, straight_dest,
               straight_length, curved_dest, curved_length, switch_number, switch_curved,
        input  ready
    );
    modport sink (
        input  valid, opcode, node_index, node_kind, node_number, straight_dest,
               straight_length, curved_dest, curved_length, switch_number, switch_curved,
        output ready
    );
endinterface

@@ hw/rtl/nstw_res_if.sv @@
interface nstw_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  result_node;
    logic [23:0] total_length;

    modport source (
        output valid, status, result_node, total_length,
        input  ready
    );
    modport sink (
        input  valid, status, result_node, total_length,
        output ready
    );
endinterface

@@ hw/rtl/nstw_ram.sv @@
module nstw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/nstw_ctrl.sv @@
module nstw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_opcode,
    input  nstw_pkg::t_dp_stat i_stat,
    output logic               o_ready,
    output nstw_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_WALK_NODE = 3'd1;
    localparam logic [2:0] ST_WALK_SW   = 3'd2;
    localparam logic [2:0] ST_FIND      = 3'd3;
    localparam logic [2:0] ST_RESULT    = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (i_opcode)
                        nstw_pkg::OP_WRITE: begin
                            o_cmd.wr_node  = 1'b1;
                            o_cmd.res_set  = 1'b1;
                            o_cmd.res_kind = nstw_pkg::RES_ZERO;
                            n_state        = ST_RESULT;
                        end
                        nstw_pkg::OP_SWITCH: begin
                            o_cmd.wr_switch = 1'b1;
                            o_cmd.res_set   = 1'b1;
                            o_cmd.res_kind  = nstw_pkg::RES_ZERO;
                            n_state         = ST_RESULT;
                        end
                        nstw_pkg::OP_WALK: begin
                            o_cmd.walk_start = 1'b1;
                            n_state          = ST_WALK_NODE;
                        end
                        nstw_pkg::OP_FIND: begin
                            o_cmd.find_start = 1'b1;
                            n_state          = ST_FIND;
                        end
                    endcase
                end
            end
            ST_WALK_NODE: begin
                o_cmd.sw_issue = 1'b1;
                n_state        = ST_WALK_SW;
            end
            ST_WALK_SW: begin
                priority if (i_stat.walk_stop) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = nstw_pkg::RES_WALK;
                    n_state        = ST_RESULT;
                end else if (i_stat.step_limit) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = nstw_pkg::RES_LOOP;
                    n_state        = ST_RESULT;
                end else begin
                    o_cmd.walk_step = 1'b1;
                    n_state         = ST_WALK_NODE;
                end
            end
            ST_FIND: begin
                priority if (i_stat.find_match) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = nstw_pkg::RES_FOUND;
                    n_state        = ST_RESULT;
                end else if (i_stat.find_last) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = nstw_pkg::RES_MISS;
                    n_state        = ST_RESULT;
                end else begin
                    o_cmd.find_next = 1'b1;
                end
            end
            ST_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/nstw_dp.sv @@
module nstw_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nstw_pkg::t_req     i_req,
    input  nstw_pkg::t_dp_cmd  i_cmd,
    output nstw_pkg::t_dp_stat o_stat,
    input  logic               i_res_ready,
    output logic               o_res_valid,
    output logic [1:0]         o_status,
    output logic [7:0]         o_result_node,
    output logic [23:0]        o_total_length
);

    localparam int AW  = nstw_pkg::NODE_AW;
    localparam int SAW = nstw_pkg::SW_AW;
    localparam int LB  = nstw_pkg::LENGTH_BITS;
    localparam int TW  = nstw_pkg::TOTAL_W;
    localparam int SW  = nstw_pkg::STEP_W;
    localparam int SWITCHES_N = nstw_pkg::SWITCHES;

    nstw_pkg::t_node node_wdata;
    nstw_pkg::t_node node_q;
    nstw_pkg::t_node node_cur;
    nstw_pkg::t_node r_node;
    logic [nstw_pkg::NODE_W-1:0] node_q_raw;
    logic [AW-1:0]  node_waddr;
    logic [AW-1:0]  node_raddr;
    logic           node_we;

    logic           sw_we;
    logic [SAW-1:0] sw_waddr;
    logic [SAW-1:0] sw_raddr;
    logic           sw_q;
    logic [SWITCHES_N-1:0] r_sw_valid;
    logic [SAW-1:0] r_sw_addr;
    logic           r_sw_ok;

    logic [7:0]     r_cur;
    logic [TW-1:0]  r_total;
    logic [SW-1:0]  r_steps;
    logic           r_oor;
    logic [AW-1:0]  r_fidx;
    logic [7:0]     r_want;

    logic           curved;
    logic [LB-1:0]  edge_len;
    logic [7:0]     edge_dest;
    logic [TW:0]    sum;
    logic [TW-1:0]  next_total;

    logic [1:0]     r_res_status;
    logic [7:0]     r_res_node;
    logic [TW-1:0]  r_res_total;

    logic           r_out_valid;
    logic [1:0]     r_out_status;
    logic [7:0]     r_out_node;
    logic [TW-1:0]  r_out_total;

    // node table
    assign node_we    = i_cmd.wr_node && (32'(i_req.node_index) < nstw_pkg::NODES);
    assign node_waddr = AW'(i_req.node_index);

    always_comb begin
        node_wdata        = '0;
        node_wdata.kind   = i_req.node_kind;
        node_wdata.number = i_req.node_number;
        node_wdata.s_dest = i_req.straight_dest;
        node_wdata.s_len  = LB'(i_req.straight_length);
        node_wdata.c_dest = i_req.curved_dest;
        node_wdata.c_len  = LB'(i_req.curved_length);
    end

    always_comb begin
        priority if (i_cmd.walk_start) begin
            node_raddr = AW'(i_req.node_index);
        end else if (i_cmd.walk_step) begin
            node_raddr = AW'(edge_dest);
        end else if (i_cmd.find_start) begin
            node_raddr = '0;
        end else if (i_cmd.find_next) begin
            node_raddr = r_fidx + AW'(1);
        end else begin
            node_raddr = r_fidx;
        end
    end

    nstw_ram #(
        .WIDTH (nstw_pkg::NODE_W),
        .DEPTH (nstw_pkg::NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_raddr (node_raddr),
        .o_rdata (node_q_raw)
    );

    assign node_q   = nstw_pkg::t_node'(node_q_raw);
    assign node_cur = r_oor ? nstw_pkg::t_node'('0) : node_q;

    // switch positions
    assign sw_we    = i_cmd.wr_switch && (32'(i_req.switch_number) < nstw_pkg::SWITCHES);
    assign sw_waddr = SAW'(i_req.switch_number);
    assign sw_raddr = SAW'(node_cur.number);

    nstw_ram #(
        .WIDTH (1),
        .DEPTH (nstw_pkg::SWITCHES)
    ) u_switch_ram (
        .i_clk   (i_clk),
        .i_we    (sw_we),
        .i_waddr (sw_waddr),
        .i_wdata (i_req.switch_curved),
        .i_raddr (sw_raddr),
        .o_rdata (sw_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_valid <= '0;
        end else if (sw_we) begin
            r_sw_valid[sw_waddr] <= 1'b1;
        end
    end

    // walk step
    assign curved     = (r_node.kind == nstw_pkg::KIND_BRANCH) && r_sw_ok
                        && r_sw_valid[r_sw_addr] && sw_q;
    assign edge_len   = curved ? r_node.c_len : r_node.s_len;
    assign edge_dest  = curved ? r_node.c_dest : r_node.s_dest;
    assign sum        = {1'b0, r_total} + (TW + 1)'(edge_len);
    assign next_total = sum[TW] ? '1 : sum[TW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_cur   <= i_req.node_index;
            r_total <= '0;
            r_steps <= SW'(1);
            r_oor   <= !(32'(i_req.node_index) < nstw_pkg::NODES);
        end else if (i_cmd.walk_step) begin
            r_cur   <= edge_dest;
            r_total <= next_total;
            r_steps <= r_steps + SW'(1);
            r_oor   <= !(32'(edge_dest) < nstw_pkg::NODES);
        end
        if (i_cmd.sw_issue) begin
            r_node    <= node_cur;
            r_sw_addr <= sw_raddr;
            r_sw_ok   <= (32'(node_cur.number) < nstw_pkg::SWITCHES);
        end
        if (i_cmd.find_start) begin
            r_fidx <= '0;
            r_want <= i_req.switch_number;
        end else if (i_cmd.find_next) begin
            r_fidx <= r_fidx + AW'(1);
        end
    end

    // result
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            unique case (i_cmd.res_kind)
                nstw_pkg::RES_WALK: begin
                    r_res_status <= nstw_pkg::STAT_OK;
                    r_res_node   <= r_cur;
                    r_res_total  <= r_total;
                end
                nstw_pkg::RES_LOOP: begin
                    r_res_status <= nstw_pkg::STAT_LOOP;
                    r_res_node   <= '0;
                    r_res_total  <= '0;
                end
                nstw_pkg::RES_FOUND: begin
                    r_res_status <= nstw_pkg::STAT_OK;
                    r_res_node   <= 8'(r_fidx);
                    r_res_total  <= '0;
                end
                nstw_pkg::RES_MISS: begin
                    r_res_status <= nstw_pkg::STAT_MISS;
                    r_res_node   <= '0;
                    r_res_total  <= '0;
                end
                default: begin
                    r_res_status <= nstw_pkg::STAT_OK;
                    r_res_node   <= '0;
                    r_res_total  <= '0;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_node   <= r_res_node;
            r_out_total  <= r_res_total;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_result_node  = r_out_node;
    assign o_total_length = r_out_total;

    assign o_stat.walk_stop  = (r_node.kind == nstw_pkg::KIND_EXIT)
                               || ((r_node.kind == nstw_pkg::KIND_SENSOR) && (r_total != '0));
    assign o_stat.step_limit = (32'(r_steps) > nstw_pkg::NODES);
    assign o_stat.find_match = (node_q.kind == nstw_pkg::KIND_SENSOR) && (node_q.number == r_want);
    assign o_stat.find_last  = (r_fidx == AW'(nstw_pkg::NODES - 1));
    assign o_stat.out_free   = !r_out_valid || i_res_ready;

endmodule

@@ hw/rtl/next_sensor_track_walker_core.sv @@
// track graph walker: node table and switch table, one request at a time
// request channel i_req: opcode and node or switch fields; taken when valid and ready
// opcodes: write node, set switch, walk to the next sensor, find the node of a sensor
// response channel o_res: status, result_node, total_length, one response per request
// ready is high only while the block is idle; the request is taken in that cycle
// write node and set switch: the response is loaded into the output register once it is free
// walk: for each node visited, a node table read, then a switch table read;
//   a walk that visits more than NODES nodes without stopping ends with the loop status
// find: one node table read per cycle, from index 0 upward, so the lowest matching index wins;
//   a miss when no sensor among the NODES entries matches
// the next request is taken while a finished response still waits in the output register
// when the receiver stalls, the response holds; a further result waits in the core
// reset clears the control state, the output valid and every switch to straight
// the node table has no reset and must be written before it is walked or searched
module next_sensor_track_walker_core (
    input logic        i_clk,
    input logic        i_rst_n,
    nstw_req_if.sink   i_req,
    nstw_res_if.source o_res
);

    nstw_pkg::t_req     req;
    nstw_pkg::t_dp_cmd  cmd;
    nstw_pkg::t_dp_stat stat;
    logic               ready;

    always_comb begin
        req.node_index      = i_req.node_index;
        req.node_kind       = i_req.node_kind;
        req.node_number     = i_req.node_number;
        req.straight_dest   = i_req.straight_dest;
        req.straight_length = i_req.straight_length;
        req.curved_dest     = i_req.curved_dest;
        req.curved_length   = i_req.curved_length;
        req.switch_number   = i_req.switch_number;
        req.switch_curved   = i_req.switch_curved;
    end

    assign i_req.ready = ready;

    nstw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_req.valid),
        .i_opcode (i_req.opcode),
        .i_stat   (stat),
        .o_ready  (ready),
        .o_cmd    (cmd)
    );

    nstw_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_res_ready    (o_res.ready),
        .o_res_valid    (o_res.valid),
        .o_status       (o_res.status),
        .o_result_node  (o_res.result_node),
        .o_total_length (o_res.total_length)
    );

endmodule

@@ dv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nstw_pkg::*;

    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam bit BY_MODEL = 1'b0;
    localparam bit LITERAL  = 1'b1;
    localparam int unsigned TOTAL_CAP = (1 << TOTAL_W) - 1;
    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_PER_PHASE = 93;
    localparam int GAP_PCT [4]   = '{0, 66, 0, 20};
    localparam int STALL_PCT [4] = '{0, 0, 66, 20};

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  node;
        logic [23:0] total;
    } t_outcome;

    typedef struct packed {
        logic [1:0] op;
        t_req       req;
        logic       literal;
        t_outcome   want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    nstw_req_if req_if();
    nstw_res_if res_if();

    next_sensor_track_walker_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    always #1 i_clk = ~i_clk;

    t_node    graph [NODES];
    logic     switch_pos [SWITCHES];
    t_outcome outcomes_due [$];

    int gap_pct   = 0;
    int stall_pct = 0;
    int errors    = 0;
    int n_writes  = 0;
    int n_sets    = 0;
    int n_walks   = 0;
    int n_loops   = 0;
    int n_finds   = 0;
    int n_misses  = 0;

    function automatic t_outcome track_outcome(input logic [1:0] op, input t_req r);
        t_outcome    o;
        t_node       n;
        int unsigned cur;
        int unsigned steps;
        int unsigned total;
        logic        curved;
        bit          stop;
        o = '0;
        case (op)
            OP_WRITE: begin
                graph[r.node_index] = '{kind: r.node_kind, number: r.node_number,
                    s_dest: r.straight_dest, s_len: r.straight_length[LENGTH_BITS-1:0],
                    c_dest: r.curved_dest, c_len: r.curved_length[LENGTH_BITS-1:0]};
            end
            OP_SWITCH: begin
                switch_pos[r.switch_number] = r.switch_curved;
            end
            OP_WALK: begin
                cur   = r.node_index;
                total = 0;
                steps = 0;
                stop  = 1'b0;
                while (!stop) begin
                    if (steps > NODES) begin
                        o.status = STAT_LOOP;
                        stop = 1'b1;
                    end else begin
                        steps++;
                        n = graph[cur];
                        curved = (n.kind == KIND_BRANCH) && switch_pos[n.number];
                        if (n.kind == KIND_EXIT || (n.kind == KIND_SENSOR && total != 0)) begin
                            o.node  = cur[7:0];
                            o.total = total[23:0];
                            stop = 1'b1;
                        end else begin
                            total += curved ? n.c_len : n.s_len;
                            if (total > TOTAL_CAP) total = TOTAL_CAP;
                            cur = curved ? n.c_dest : n.s_dest;
                        end
                    end
                end
            end
            default: begin
                o.status = STAT_MISS;
                for (int i = NODES - 1; i >= 0; i--) begin
                    if (graph[i].kind == KIND_SENSOR && graph[i].number == r.switch_number) begin
                        o.status = STAT_OK;
                        o.node   = 8'(i);
                    end
                end
            end
        endcase
        return o;
    endfunction

    function automatic t_row table_row(input logic [1:0] op, input int idx,
                                       input logic [1:0] kind, input int num,
                                       input int sd, input int sl, input int cd, input int cl,
                                       input int sw, input int swc, input bit literal,
                                       input logic [1:0] st, input int nd, input int tot);
        t_row r;
        r.op                  = op;
        r.req.node_index      = idx[7:0];
        r.req.node_kind       = kind;
        r.req.node_number     = num[7:0];
        r.req.straight_dest   = sd[7:0];
        r.req.straight_length = sl[15:0];
        r.req.curved_dest     = cd[7:0];
        r.req.curved_length   = cl[15:0];
        r.req.switch_number   = sw[7:0];
        r.req.switch_curved   = swc[0];
        r.literal             = literal;
        r.want.status         = st;
        r.want.node           = nd[7:0];
        r.want.total          = tot[23:0];
        return r;
    endfunction

    function automatic t_req scrambled_request();
        t_req r;
        r.node_index      = 8'($urandom);
        r.node_kind       = 2'($urandom);
        r.node_number     = 8'($urandom);
        r.straight_dest   = 8'($urandom);
        r.straight_length = 16'($urandom);
        r.curved_dest     = 8'($urandom);
        r.curved_length   = 16'($urandom);
        r.switch_number   = 8'($urandom);
        r.switch_curved   = 1'($urandom);
        return r;
    endfunction

    function automatic logic [15:0] edge_length();
        case ($urandom_range(3))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(1, 15));
        endcase
    endfunction

    // small switch and sensor numbers so that finds hit and branches share switches
    function automatic logic [7:0] track_number();
        if ($urandom_range(3) != 0) return 8'($urandom_range(0, 15));
        return 8'($urandom);
    endfunction

    task automatic random_request(output logic [1:0] op, output t_req r);
        int unsigned pick;
        int unsigned k;
        r    = scrambled_request();
        pick = $urandom_range(99);
        if (pick < 35) begin
            op = OP_WRITE;
            k  = $urandom_range(99);
            r.node_kind = (k < 35) ? KIND_PLAIN : (k < 60) ? KIND_SENSOR :
                          (k < 85) ? KIND_BRANCH : KIND_EXIT;
            r.node_number     = track_number();
            r.straight_length = edge_length();
            r.curved_length   = edge_length();
        end else if (pick < 45) begin
            op = OP_SWITCH;
            r.switch_number = track_number();
        end else if (pick < 75) begin
            op = OP_WALK;
        end else begin
            op = OP_FIND;
            r.switch_number = track_number();
        end
    endtask

    task automatic issue(input logic [1:0] op, input t_req r, input bit literal,
                         input t_outcome fixed);
        t_outcome o;
        bit       took;
        while ($urandom_range(99) < gap_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid           <= 1'b1;
        req_if.opcode          <= op;
        req_if.node_index      <= r.node_index;
        req_if.node_kind       <= r.node_kind;
        req_if.node_number     <= r.node_number;
        req_if.straight_dest   <= r.straight_dest;
        req_if.straight_length <= r.straight_length;
        req_if.curved_dest     <= r.curved_dest;
        req_if.curved_length   <= r.curved_length;
        req_if.switch_number   <= r.switch_number;
        req_if.switch_curved   <= r.switch_curved;
        // ready is settled mid-cycle, so the handshake is judged before the edge
        do begin
            @(negedge i_clk);
            took = (req_if.ready === 1'b1);
            @(posedge i_clk);
        end while (!took);
        o = track_outcome(op, r);
        outcomes_due.push_back(literal ? fixed : o);
        case (op)
            OP_WRITE:  n_writes++;
            OP_SWITCH: n_sets++;
            OP_WALK: begin
                n_walks++;
                if (o.status == STAT_LOOP) n_loops++;
            end
            default: begin
                n_finds++;
                if (o.status == STAT_MISS) n_misses++;
            end
        endcase
    endtask

    initial begin : stimulus
        t_row       directed_rows [DIRECTED_ROWS];
        t_req       r;
        logic [1:0] op;
        i_rst_n                <= 1'b0;
        req_if.valid           <= 1'b0;
        req_if.opcode          <= OP_WRITE;
        req_if.node_index      <= '0;
        req_if.node_kind       <= '0;
        req_if.node_number     <= '0;
        req_if.straight_dest   <= '0;
        req_if.straight_length <= '0;
        req_if.curved_dest     <= '0;
        req_if.curved_length   <= '0;
        req_if.switch_number   <= '0;
        req_if.switch_curved   <= 1'b0;
        for (int i = 0; i < SWITCHES; i++) switch_pos[i] = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill the whole graph: a chain of maximum-length edges into the exit at node 0
        for (int i = 0; i < NODES; i++) begin
            r = scrambled_request();
            r.node_index      = 8'(i);
            r.node_kind       = (i == 0) ? KIND_EXIT : KIND_PLAIN;
            r.straight_dest   = 8'(i + 1);
            r.straight_length = 16'hFFFF;
            issue(OP_WRITE, r, BY_MODEL, '0);
        end

        directed_rows = '{
            table_row(OP_WALK, 1, KIND_PLAIN, 0, 0, 0, 0, 0, 0, 0, BY_MODEL, STAT_OK, 0, 0),
            table_row(OP_FIND, 0, KIND_PLAIN, 0, 0, 0, 0, 0, 7, 0, LITERAL, STAT_MISS, 0, 0),
            table_row(OP_WALK, 0, KIND_PLAIN, 0, 0, 0, 0, 0, 0, 0, LITERAL, STAT_OK, 0, 0),
            // plain node looping on itself
            table_row(OP_WRITE, 5, KIND_PLAIN, 0, 5, 1, 5, 1, 0, 0, LITERAL, STAT_OK, 0, 0),
            table_row(OP_WALK, 5, KIND_PLAIN, 0, 0, 0, 0, 0, 0, 0, LITERAL, STAT_LOOP, 0, 0),
            // sensor looping on itself with no distance never stops
            table_row(OP_WRITE, 6, KIND_SENSOR, 7, 6, 0, 6, 0, 0, 0, LITERAL, STAT_OK, 0, 0),
            table_row(OP_WALK, 6, KIND_PLAIN, 0, 0, 0, 0, 0, 0, 0, LITERAL, STAT_LOOP, 0, 0),
            table_row(OP_WRITE, 200, KIND_SENSOR, 7, 201, 65535, 0, 0, 0, 0,
                      LITERAL, STAT_OK, 0, 0),
            // lowest matching index wins
            table_row(OP_FIND, 0, KIND_PLAIN, 0, 0, 0, 0, 0, 7, 0, LITERAL, STAT_OK, 6, 0),
            table_row(OP_WRITE, 10, KIND_BRANCH, 255, 11, 100, 200, 65535, 0, 0,
                      LITERAL, STAT_OK, 0, 0),
            table_row(OP_WALK, 10, KIND_PLAIN, 0, 0, 0, 0, 0, 0, 0, BY_MODEL, STAT_OK, 0, 0),
            table_row(OP_SWITCH, 0, KIND_PLAIN, 0, 0, 0, 0, 0, 255, 1, LITERAL, STAT_OK, 0, 0),
            table_row(OP_WALK, 10, KIND_PLAIN, 0, 0, 0, 0, 0, 0, 0, LITERAL, STAT_OK, 200, 65535),
            // walk starting on a sensor passes it
            table_row(OP_WALK, 200, KIND_PLAIN, 0, 0, 0, 0, 0, 0, 0, BY_MODEL, STAT_OK, 0, 0),
            table_row(OP_SWITCH, 0, KIND_PLAIN, 0, 0, 0, 0, 0, 0, 1, LITERAL, STAT_OK, 0, 0),
            table_row(OP_WRITE, 20, KIND_BRANCH, 0, 21, 0, 255, 65535, 0, 0,
                      LITERAL, STAT_OK, 0, 0),
            table_row(OP_WALK, 20, KIND_PLAIN, 0, 0, 0, 0, 0, 0, 0, BY_MODEL, STAT_OK, 0, 0),
            table_row(OP_SWITCH, 0, KIND_PLAIN, 0, 0, 0, 0, 0, 0, 0, LITERAL, STAT_OK, 0, 0),
            table_row(OP_WALK, 20, KIND_PLAIN, 0, 0, 0, 0, 0, 0, 0, BY_MODEL, STAT_OK, 0, 0),
            table_row(OP_WRITE, 255, KIND_EXIT, 255, 255, 65535, 255, 65535, 0, 0,
                      LITERAL, STAT_OK, 0, 0),
            table_row(OP_WALK, 254, KIND_PLAIN, 0, 0, 0, 0, 0, 0, 0,
                      LITERAL, STAT_OK, 255, 65535),
            table_row(OP_WRITE, 1, KIND_SENSOR, 0, 2, 1, 0, 0, 0, 0, LITERAL, STAT_OK, 0, 0),
            table_row(OP_FIND, 0, KIND_PLAIN, 0, 0, 0, 0, 0, 0, 0, LITERAL, STAT_OK, 1, 0),
            // an exit carrying the number sought is no match
            table_row(OP_FIND, 0, KIND_PLAIN, 0, 0, 0, 0, 0, 255, 0, LITERAL, STAT_MISS, 0, 0),
            table_row(OP_WALK, 1, KIND_PLAIN, 0, 0, 0, 0, 0, 0, 0, BY_MODEL, STAT_OK, 0, 0)
        };

        gap_pct   = GAP_PCT[3];
        stall_pct = STALL_PCT[3];
        foreach (directed_rows[i])
            issue(directed_rows[i].op, directed_rows[i].req, directed_rows[i].literal,
                  directed_rows[i].want);

        for (int ph = 0; ph < 4; ph++) begin
            gap_pct   = GAP_PCT[ph];
            stall_pct = STALL_PCT[ph];
            repeat (RANDOM_PER_PHASE) begin
                random_request(op, r);
                issue(op, r, BY_MODEL, '0);
            end
        end

        req_if.valid <= 1'b0;
        stall_pct = 0;
        while (outcomes_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("covered %0d node writes, %0d switch sets, %0d walks (%0d looped),",
                 n_writes, n_sets, n_walks, n_loops);
        $display("and %0d sensor searches (%0d missed) under four idling patterns",
                 n_finds, n_misses);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : reply_sink
        t_outcome want;
        res_if.ready <= 1'b0;
        forever begin
            // valid and ready are settled mid-cycle and decide the coming edge
            @(negedge i_clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                if (outcomes_due.size() == 0) begin
                    $display("%0t: response with none pending: status %0d node %0d total %0d",
                             $time, res_if.status, res_if.result_node, res_if.total_length);
                    errors++;
                end else begin
                    want = outcomes_due.pop_front();
                    if (res_if.status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, res_if.status);
                        errors++;
                    end
                    if (res_if.result_node !== want.node) begin
                        $display("%0t: result_node expected %0d, got %0d",
                                 $time, want.node, res_if.result_node);
                        errors++;
                    end
                    if (res_if.total_length !== want.total) begin
                        $display("%0t: total_length expected %0d, got %0d",
                                 $time, want.total, res_if.total_length);
                        errors++;
                    end
                end
            end
            @(posedge i_clk);
            res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin : watchdog
        #4_000_000;
        $display("%0t: timed out with %0d responses outstanding", $time, outcomes_due.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ next_sensor_track_walker_core.f @@
hw/rtl/nstw_pkg.sv
hw/rtl/nstw_req_if.sv
hw/rtl/nstw_res_if.sv
hw/rtl/nstw_ram.sv
hw/rtl/nstw_ctrl.sv
hw/rtl/nstw_dp.sv
hw/rtl/next_sensor_track_walker_core.sv
dv/tb_top.sv
